>>> hdl/running_variance_three_axis_core_assert.svh
// Assertion macros for the running variance core.
`ifndef RUNNING_VARIANCE_THREE_AXIS_CORE_ASSERT_SVH
`define RUNNING_VARIANCE_THREE_AXIS_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RV3_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("rv3: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define RV3_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("rv3: next-cycle check failed");

`endif

>>> hdl/rv3_pkg.sv
// Shared types and constants for the running variance core.
`default_nettype none
package rv3_pkg;

  localparam int COUNT_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int SAMPLE_W   = 16;
  localparam int MEAN_OUT_W = 32;
  localparam int VAR_W      = 47;
  localparam int CNT_OUT_W  = 32;
  localparam int ACC_W      = 64;
  localparam int STEP_W     = 7;
  localparam int AXES       = 3;
  localparam int MIN_FOR_VAR = 2;

  typedef enum logic {
    RV3_OP_DIV = 1'b0,
    RV3_OP_MUL = 1'b1
  } rv3_op_t;

  typedef struct packed {
    logic              start;
    rv3_op_t           op;
    logic [STEP_W-1:0] steps;
  } rv3_cmd_t;

endpackage
`default_nettype wire

>>> hdl/rv3_if.sv
// Input and result channel interfaces of the running variance core.
`default_nettype none
interface rv3_in_if import rv3_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_x;
  logic signed [SAMPLE_W-1:0] sample_y;
  logic signed [SAMPLE_W-1:0] sample_z;
  logic                       clear_first;

  modport source (output valid, sample_x, sample_y, sample_z, clear_first, input ready);
  modport sink (input valid, sample_x, sample_y, sample_z, clear_first, output ready);
endinterface

interface rv3_out_if import rv3_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [MEAN_OUT_W-1:0] mean_x;
  logic signed [MEAN_OUT_W-1:0] mean_y;
  logic signed [MEAN_OUT_W-1:0] mean_z;
  logic        [VAR_W-1:0]      var_x;
  logic        [VAR_W-1:0]      var_y;
  logic        [VAR_W-1:0]      var_z;
  logic        [CNT_OUT_W-1:0]  samples_seen;

  modport source (output valid, mean_x, mean_y, mean_z, var_x, var_y, var_z, samples_seen,
                  input ready);
  modport sink (input valid, mean_x, mean_y, mean_z, var_x, var_y, var_z, samples_seen,
                output ready);
endinterface
`default_nettype wire

>>> hdl/rv3_iter_unit.sv
// Shared bit-serial unit: restoring divide or shift-add multiply, one bit per cycle.
`default_nettype none
module rv3_iter_unit import rv3_pkg::*; #(
  parameter int OPW = 41
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire rv3_cmd_t         cmd,
  input  wire logic [ACC_W-1:0] load_word,
  input  wire logic [OPW-1:0]   operand,
  output logic                  done,
  output logic [OPW:0]          hi,
  output logic [ACC_W-1:0]      lo
);

  localparam int W = OPW + 1;

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] cnt_r;
  rv3_op_t           op_r;
  logic [OPW-1:0]    opnd_r;
  logic [W-1:0]      acc_r;
  logic [ACC_W-1:0]  sh_r;

  logic              is_div;
  logic [W-1:0]      lhs;
  logic [W-1:0]      rhs;
  logic [W:0]        sum;
  logic [W-1:0]      acc_nxt;
  logic [ACC_W-1:0]  sh_nxt;

  // One adder serves both: subtract-and-compare for divide, add for multiply.
  always_comb begin
    is_div = (op_r == RV3_OP_DIV);
    lhs    = is_div ? {acc_r[W-2:0], sh_r[ACC_W-1]} : acc_r;
    rhs    = (is_div || sh_r[0]) ? {1'b0, opnd_r} : '0;
    sum    = {1'b0, lhs} + {1'b0, (is_div ? ~rhs : rhs)} + {{W{1'b0}}, is_div};
    if (is_div) begin
      acc_nxt = sum[W] ? sum[W-1:0] : lhs;
      sh_nxt  = {sh_r[ACC_W-2:0], sum[W]};
    end else begin
      acc_nxt = sum[W:1];
      sh_nxt  = {sum[0], sh_r[ACC_W-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == STEP_W'(1));
      if (cmd.start) begin
        busy_r <= 1'b1;
        cnt_r  <= cmd.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - STEP_W'(1);
        if (cnt_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_r   <= cmd.op;
      opnd_r <= operand;
      acc_r  <= '0;
      sh_r   <= load_word;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      sh_r  <= sh_nxt;
    end
  end

  assign done = done_r;
  assign hi   = acc_r;
  assign lo   = sh_r;

endmodule
`default_nettype wire

>>> hdl/running_variance_three_axis_core.sv
// Running mean and variance of three-axis sensor samples (Welford update).
// in_ch carries one signed sample per axis and a clear flag; an item is taken
// when valid and ready are high at a clock edge. in_ch.ready is high only while
// the core is idle. out_ch carries the updated Q16.FRAC_BITS means, the
// unbiased variances (zero below two samples) and the saturating count.
// Each axis fold runs one divide and one multiply of M = 17 + FRAC_BITS steps
// each on the shared bit-serial unit; each variance is a 64-step divide, or is
// set to zero without the unit below two samples. A new item is taken only
// once the last result is registered, and the bit-serial unit sets the rate.
// The result register holds while the receiver stalls, and the core takes
// and works on the next item meanwhile, waiting only to hand over its own
// result. Reset clears the count, means and sums and drops any pending result.
`default_nettype none
module running_variance_three_axis_core import rv3_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  rv3_in_if.sink   in_ch,
  rv3_out_if.source out_ch
);

  localparam int MEAN_W = SAMPLE_W + FRAC_BITS;
  localparam int MAG_W  = MEAN_W + 1;
  localparam int OPW    = (MAG_W > COUNT_BITS) ? MAG_W : COUNT_BITS;
  localparam int PROD_W = 2 * MAG_W;
  localparam int INC_W  = PROD_W - FRAC_BITS;
  localparam logic [1:0] AXIS_LAST = 2'(AXES - 1);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b0000_0000_0001,
    S_D1     = 12'b0000_0000_0010,
    S_MSTART = 12'b0000_0000_0100,
    S_MDIV   = 12'b0000_0000_1000,
    S_UPD    = 12'b0000_0001_0000,
    S_D2     = 12'b0000_0010_0000,
    S_PSTART = 12'b0000_0100_0000,
    S_MMUL   = 12'b0000_1000_0000,
    S_ACC    = 12'b0001_0000_0000,
    S_VSTART = 12'b0010_0000_0000,
    S_VDIV   = 12'b0100_0000_0000,
    S_FIN    = 12'b1000_0000_0000
  } state_t;

  state_t                       state_r;
  logic [1:0]                   axis_r;
  logic [COUNT_BITS-1:0]        n_r;
  logic signed [SAMPLE_W-1:0]   samp_r [AXES];
  logic signed [MEAN_W-1:0]     mean_r [AXES];
  logic [ACC_W-1:0]             sum_r  [AXES];
  logic [VAR_W-1:0]             var_r  [AXES];
  logic [MAG_W-1:0]             d1_r;
  logic [MAG_W-1:0]             d2_r;

  logic                         out_valid_r;
  logic signed [MEAN_OUT_W-1:0] mean_o_r [AXES];
  logic [VAR_W-1:0]             var_o_r  [AXES];
  logic [CNT_OUT_W-1:0]         cnt_o_r;

  rv3_cmd_t                     cmd_c;
  logic [ACC_W-1:0]             load_c;
  logic [OPW-1:0]               opnd_c;
  logic                         u_done;
  logic [OPW:0]                 u_hi;
  logic [ACC_W-1:0]             u_lo;

  logic                         accept;
  logic                         out_load;
  logic [COUNT_BITS-1:0]        n_base;
  logic [COUNT_BITS-1:0]        n_nxt;
  logic [MEAN_W-1:0]            x_c;
  logic [MAG_W-1:0]             mean_ext;
  logic [MAG_W-1:0]             d_c;
  logic [MAG_W-1:0]             mag_d1;
  logic [MAG_W-1:0]             mag_d2;
  logic [MAG_W-1:0]             mean_upd;
  logic [PROD_W-1:0]            prod_c;
  logic [INC_W-1:0]             inc_c;
  logic [ACC_W:0]               sum_add;
  logic                         few_samples;

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_load = (state_r == S_FIN) && (!out_valid_r || out_ch.ready);

  always_comb begin
    n_base      = in_ch.clear_first ? '0 : n_r;
    n_nxt       = (n_base == '1) ? n_base : n_base + COUNT_BITS'(1);
    x_c         = {samp_r[axis_r], {FRAC_BITS{1'b0}}};
    mean_ext    = {mean_r[axis_r][MEAN_W-1], mean_r[axis_r]};
    d_c         = {x_c[MEAN_W-1], x_c} - mean_ext;
    mag_d1      = d1_r[MAG_W-1] ? -d1_r : d1_r;
    mag_d2      = d2_r[MAG_W-1] ? -d2_r : d2_r;
    // Truncated quotient moves the mean toward the sample.
    mean_upd    = d1_r[MAG_W-1] ? mean_ext - u_lo[MAG_W-1:0] : mean_ext + u_lo[MAG_W-1:0];
    prod_c      = {u_hi[MAG_W-1:0], u_lo[ACC_W-1 -: MAG_W]};
    inc_c       = prod_c[PROD_W-1:FRAC_BITS];
    sum_add     = {1'b0, sum_r[axis_r]} + (ACC_W+1)'(inc_c);
    few_samples = (n_r < COUNT_BITS'(MIN_FOR_VAR));
  end

  // Unit commands: start pulses come from the launch states only.
  always_comb begin
    cmd_c  = '{start: 1'b0, op: RV3_OP_DIV, steps: STEP_W'(MAG_W)};
    load_c = {mag_d1, {(ACC_W-MAG_W){1'b0}}};
    opnd_c = OPW'(n_r);
    unique case (state_r)
      S_MSTART: begin
        cmd_c.start = 1'b1;
      end
      S_PSTART: begin
        cmd_c.start = 1'b1;
        cmd_c.op    = RV3_OP_MUL;
        load_c      = ACC_W'(mag_d2);
        opnd_c      = OPW'(mag_d1);
      end
      S_VSTART: begin
        cmd_c.start = !few_samples;
        cmd_c.steps = STEP_W'(ACC_W);
        load_c      = sum_r[axis_r];
        opnd_c      = OPW'(n_r - COUNT_BITS'(1));
      end
      default: begin
        cmd_c.start = 1'b0;
      end
    endcase
  end

  rv3_iter_unit #(
    .OPW (OPW)
  ) u_unit (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd_c),
    .load_word (load_c),
    .operand   (opnd_c),
    .done      (u_done),
    .hi        (u_hi),
    .lo        (u_lo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      axis_r  <= '0;
      n_r     <= '0;
      for (int i = 0; i < AXES; i++) begin
        mean_r[i] <= '0;
        sum_r[i]  <= '0;
      end
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            n_r     <= n_nxt;
            axis_r  <= '0;
            state_r <= S_D1;
            if (in_ch.clear_first) begin
              for (int i = 0; i < AXES; i++) begin
                mean_r[i] <= '0;
                sum_r[i]  <= '0;
              end
            end
          end
        end
        S_D1:     state_r <= S_MSTART;
        S_MSTART: state_r <= S_MDIV;
        S_MDIV: begin
          if (u_done) begin
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          mean_r[axis_r] <= mean_upd[MEAN_W-1:0];
          state_r        <= S_D2;
        end
        S_D2:     state_r <= S_PSTART;
        S_PSTART: state_r <= S_MMUL;
        S_MMUL: begin
          if (u_done) begin
            state_r <= S_ACC;
          end
        end
        S_ACC: begin
          sum_r[axis_r] <= sum_add[ACC_W] ? '1 : sum_add[ACC_W-1:0];
          if (axis_r == AXIS_LAST) begin
            axis_r  <= '0;
            state_r <= S_VSTART;
          end else begin
            axis_r  <= axis_r + 2'd1;
            state_r <= S_D1;
          end
        end
        S_VSTART: begin
          if (!few_samples) begin
            state_r <= S_VDIV;
          end else if (axis_r == AXIS_LAST) begin
            axis_r  <= '0;
            state_r <= S_FIN;
          end else begin
            axis_r <= axis_r + 2'd1;
          end
        end
        S_VDIV: begin
          if (u_done) begin
            if (axis_r == AXIS_LAST) begin
              axis_r  <= '0;
              state_r <= S_FIN;
            end else begin
              axis_r  <= axis_r + 2'd1;
              state_r <= S_VSTART;
            end
          end
        end
        S_FIN: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Per-item working registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      samp_r[0] <= in_ch.sample_x;
      samp_r[1] <= in_ch.sample_y;
      samp_r[2] <= in_ch.sample_z;
    end
    if (state_r == S_D1) begin
      d1_r <= d_c;
    end
    if (state_r == S_D2) begin
      d2_r <= d_c;
    end
    if (state_r == S_VSTART && few_samples) begin
      var_r[axis_r] <= '0;
    end
    if (state_r == S_VDIV && u_done) begin
      var_r[axis_r] <= (|u_lo[ACC_W-1:VAR_W]) ? '1 : u_lo[VAR_W-1:0];
    end
  end

  // Result register: hold while the receiver stalls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      for (int i = 0; i < AXES; i++) begin
        mean_o_r[i] <= MEAN_OUT_W'(mean_r[i]);
        var_o_r[i]  <= var_r[i];
      end
      cnt_o_r <= CNT_OUT_W'(n_r);
    end
  end

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.mean_x       = mean_o_r[0];
  assign out_ch.mean_y       = mean_o_r[1];
  assign out_ch.mean_z       = mean_o_r[2];
  assign out_ch.var_x        = var_o_r[0];
  assign out_ch.var_y        = var_o_r[1];
  assign out_ch.var_z        = var_o_r[2];
  assign out_ch.samples_seen = cnt_o_r;

`include "running_variance_three_axis_core_assert.svh"

  `RV3_ASSERT_IMPL(a_state_onehot, clk, rst_n, 1'b1, $onehot(state_r))
  `RV3_ASSERT_IMPL(a_done_in_wait, clk, rst_n, u_done, state_r == S_MDIV || state_r == S_MMUL || state_r == S_VDIV)
  `RV3_ASSERT_NEXT(a_accept_starts, clk, rst_n, accept, state_r == S_D1)
  `RV3_ASSERT_NEXT(a_fin_holds, clk, rst_n, state_r == S_FIN && out_valid_r && !out_ch.ready, state_r == S_FIN)
  `RV3_ASSERT_IMPL(a_count_nonzero, clk, rst_n, out_valid_r, cnt_o_r != '0)

endmodule
`default_nettype wire
